// ----- hdl/rgbp_pkg.sv -----
`timescale 1ns / 1ps

package rgbp_pkg;

  // item kinds on the input channel
  localparam logic       ACT_CHAR    = 1'b0;
  localparam logic       ACT_EOL     = 1'b1;

  // target codes, meaningful at end of line
  localparam logic [1:0] TGT_FLOOR   = 2'd0;
  localparam logic [1:0] TGT_CEILING = 2'd1;

  // character codes
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  localparam logic [11:0] MAX_PART   = 12'd255;
  localparam logic [1:0]  LAST_COMMA = 2'd2;

  typedef enum logic [2:0] {
    PH_BEFORE = 3'b001,
    PH_DIGITS = 3'b010,
    PH_AFTER  = 3'b100
  } phase_t;

  // summary of the line parsed so far
  typedef struct packed {
    logic        ok;
    logic [23:0] color;
  } line_sum_t;

endpackage

// ----- hdl/rgbp_if.sv -----
`timescale 1ns / 1ps

interface rgbp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_code;
  logic [1:0] target;

  modport source (output valid, action, char_code, target, input ready);
  modport sink   (input valid, action, char_code, target, output ready);
endinterface

interface rgbp_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [23:0] packed_color;
  logic [23:0] floor_value;
  logic [23:0] ceiling_value;
  logic        floor_present;
  logic        ceiling_present;

  modport source (output valid, status, packed_color, floor_value, ceiling_value,
                  floor_present, ceiling_present, input ready);
  modport sink   (input valid, status, packed_color, floor_value, ceiling_value,
                  floor_present, ceiling_present, output ready);
endinterface

// ----- hdl/rgbp_line.sv -----
`timescale 1ns / 1ps

module rgbp_line (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 action,
  input  logic [7:0]           char_code,
  output rgbp_pkg::line_sum_t  sum
);
  import rgbp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [7:0]  red_r, red_nxt;
  logic [7:0]  green_r, green_nxt;
  logic        err_r, err_nxt;

  logic        is_digit;
  logic        is_blank;
  logic [11:0] acc_x10;
  logic [11:0] acc_new;

  assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign is_blank = ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR)) ||
                    (char_code == CHAR_SPACE);
  // times ten as 8x + 2x; low nibble of an ASCII digit is its value
  assign acc_x10  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0};
  assign acc_new  = acc_x10 + {8'd0, char_code[3:0]};

  assign sum.ok    = !err_r && (phase_r != PH_BEFORE) && (count_r == LAST_COMMA);
  assign sum.color = {red_r, green_r, acc_r};

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    count_nxt = count_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    err_nxt   = err_r;
    if (step) begin
      if (action == ACT_EOL) begin
        // clear line state for the next line
        phase_nxt = PH_BEFORE;
        acc_nxt   = 8'd0;
        count_nxt = 2'd0;
        red_nxt   = 8'd0;
        green_nxt = 8'd0;
        err_nxt   = 1'b0;
      end else if (!err_r) begin
        if (is_digit) begin
          if (phase_r == PH_AFTER || acc_new > MAX_PART) begin
            err_nxt = 1'b1;
          end else begin
            acc_nxt   = acc_new[7:0];
            phase_nxt = PH_DIGITS;
          end
        end else if (is_blank) begin
          if (phase_r != PH_BEFORE) begin
            phase_nxt = PH_AFTER;
          end
        end else if (char_code == CHAR_COMMA) begin
          if (phase_r == PH_BEFORE || count_r >= LAST_COMMA) begin
            err_nxt = 1'b1;
          end else begin
            if (count_r == 2'd0) begin
              red_nxt = acc_r;
            end else begin
              green_nxt = acc_r;
            end
            count_nxt = count_r + 2'd1;
            acc_nxt   = 8'd0;
            phase_nxt = PH_BEFORE;
          end
        end else begin
          err_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BEFORE;
      acc_r   <= 8'd0;
      count_r <= 2'd0;
      red_r   <= 8'd0;
      green_r <= 8'd0;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      count_r <= count_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ----- hdl/decimal_rgb_triple_parser_unit.sv -----
`timescale 1ns / 1ps
// An end-of-line item waits in the input register and advances into the result
// register as long as the result register is free or being taken in that cycle.
// Throughput: one item per cycle; characters never wait on the result register,
// and an end-of-line item advances when the result register is free or taken.
// Characters give no result. Synchronous active-low reset clears line state,
// both color stores and their present flags, and empties both registers.

module decimal_rgb_triple_parser_unit (
  input  logic       clk,
  input  logic       rst_n,
  rgbp_in_if.sink    in_chan,
  rgbp_out_if.source out_chan
);
  import rgbp_pkg::*;

  // input register
  logic       in_vld_r, in_vld_nxt;
  logic       act_r;
  logic [7:0] chr_r;
  logic [1:0] tgt_r;
  logic       in_take;
  logic       adv;
  logic       eol;

  line_sum_t  sum;

  // colour stores
  logic [23:0] floor_r, floor_nxt;
  logic [23:0] ceil_r, ceil_nxt;
  logic        floor_flag_r, floor_flag_nxt;
  logic        ceil_flag_r, ceil_flag_nxt;
  logic        bad;

  // result register
  logic        out_vld_r, out_vld_nxt;
  logic        status_r;
  logic [23:0] color_r;
  logic [23:0] floor_out_r;
  logic [23:0] ceil_out_r;
  logic        floor_pres_r;
  logic        ceil_pres_r;

  assign eol     = (act_r == ACT_EOL);
  // characters never need the result register
  assign adv     = in_vld_r && (!eol || !out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || adv;
  assign in_take = in_chan.valid && in_chan.ready;

  assign in_vld_nxt  = in_take ? 1'b1 : (adv ? 1'b0 : in_vld_r);
  assign out_vld_nxt = (adv && eol) ? 1'b1 : (out_chan.ready ? 1'b0 : out_vld_r);

  rgbp_line u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .action    (act_r),
    .char_code (chr_r),
    .sum       (sum)
  );

  always_comb begin
    floor_nxt      = floor_r;
    ceil_nxt       = ceil_r;
    floor_flag_nxt = floor_flag_r;
    ceil_flag_nxt  = ceil_flag_r;
    bad            = !sum.ok;
    if (sum.ok) begin
      if (tgt_r == TGT_FLOOR) begin
        if (floor_flag_r) begin
          bad = 1'b1;
        end else begin
          floor_nxt      = sum.color;
          floor_flag_nxt = 1'b1;
        end
      end else if (tgt_r == TGT_CEILING) begin
        if (ceil_flag_r) begin
          bad = 1'b1;
        end else begin
          ceil_nxt      = sum.color;
          ceil_flag_nxt = 1'b1;
        end
      end else begin
        bad = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      floor_r      <= 24'd0;
      ceil_r       <= 24'd0;
      floor_flag_r <= 1'b0;
      ceil_flag_r  <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (adv && eol) begin
        floor_r      <= floor_nxt;
        ceil_r       <= ceil_nxt;
        floor_flag_r <= floor_flag_nxt;
        ceil_flag_r  <= ceil_flag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      act_r <= in_chan.action;
      chr_r <= in_chan.char_code;
      tgt_r <= in_chan.target;
    end
    if (adv && eol) begin
      status_r     <= bad;
      color_r      <= bad ? 24'd0 : sum.color;
      floor_out_r  <= floor_nxt;
      ceil_out_r   <= ceil_nxt;
      floor_pres_r <= floor_flag_nxt;
      ceil_pres_r  <= ceil_flag_nxt;
    end
  end

  assign out_chan.valid           = out_vld_r;
  assign out_chan.status          = status_r;
  assign out_chan.packed_color    = color_r;
  assign out_chan.floor_value     = floor_out_r;
  assign out_chan.ceiling_value   = ceil_out_r;
  assign out_chan.floor_present   = floor_pres_r;
  assign out_chan.ceiling_present = ceil_pres_r;

endmodule

// ----- hdl/rgbp_checker.sv -----
`timescale 1ns / 1ps

module rgbp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_status,
  input logic [23:0] out_packed_color,
  input logic [23:0] out_floor_value,
  input logic [23:0] out_ceiling_value,
  input logic        out_floor_present,
  input logic        out_ceiling_present
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_packed_color) &&
                                $stable(out_status))
    else $error("result changed while stalled");

  // an error result carries no colour
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_packed_color == 24'd0)
    else $error("error result with nonzero colour");

  // an accepted line was stored in one of the two targets
  a_ok_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status |->
      (out_floor_present && out_floor_value == out_packed_color) ||
      (out_ceiling_present && out_ceiling_value == out_packed_color))
    else $error("accepted colour not in any store");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind decimal_rgb_triple_parser_unit rgbp_checker u_rgbp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_status          (out_chan.status),
  .out_packed_color    (out_chan.packed_color),
  .out_floor_value     (out_chan.floor_value),
  .out_ceiling_value   (out_chan.ceiling_value),
  .out_floor_present   (out_chan.floor_present),
  .out_ceiling_present (out_chan.ceiling_present)
);
